@@ rtl/bresenham_line_rasterizer_assert.svh @@
// Assertion macros shared by the rasterizer modules.
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BRL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A condition in one cycle that implies a consequence in the next.
`define BRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/brl_pkg.sv @@
// Package with the types and constants of the line rasterizer.
package brl_pkg;

  localparam int unsigned CoordW     = 6;
  localparam int unsigned CoordBits  = 6;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned IncSW      = CoordW + 1;
  localparam int unsigned IncDW      = CoordW + 2;
  localparam int unsigned DecW       = 2 * CoordW + 2;

  typedef struct packed {
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_end;
  } req_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic              last_pixel;
  } pix_t;

  typedef struct packed {
    logic [CoordW-1:0]      x;
    logic [CoordW-1:0]      y;
    logic [CoordW-1:0]      stop_x;
    logic signed [DecW-1:0] decision;
    logic [IncSW-1:0]       inc_straight;
    logic signed [IncDW-1:0] inc_diagonal;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

@@ rtl/brl_front.sv @@
// Front end: accepts a line request and derives its start point and increments.
module brl_front #(
  parameter int unsigned COORD_BITS = brl_pkg::CoordBits
) (
  input  logic          push_i,
  input  brl_pkg::req_t req_i,
  input  logic          q_full_i,
  output logic          full_o,
  output logic          q_wr_o,
  output brl_pkg::cmd_t cmd_o
);

  logic [COORD_BITS-1:0] xa, ya, xb, yb;
  logic [COORD_BITS-1:0] dx, dy;
  logic signed [brl_pkg::DecW-1:0] dx_s, dy_s;
  logic signed [brl_pkg::DecW-1:0] diff_s;

  assign xa = req_i.x_start[COORD_BITS-1:0];
  assign ya = req_i.y_start[COORD_BITS-1:0];
  assign xb = req_i.x_end[COORD_BITS-1:0];
  assign yb = req_i.y_end[COORD_BITS-1:0];

  assign dx = (xa > xb) ? (xa - xb) : (xb - xa);
  assign dy = (ya > yb) ? (ya - yb) : (yb - ya);

  assign dx_s   = signed'(brl_pkg::DecW'(dx));
  assign dy_s   = signed'(brl_pkg::DecW'(dy));
  assign diff_s = dy_s - dx_s;

  always_comb begin
    if (xa > xb) begin
      cmd_o.x      = brl_pkg::CoordW'(xb);
      cmd_o.y      = brl_pkg::CoordW'(yb);
      cmd_o.stop_x = brl_pkg::CoordW'(xa);
    end else begin
      cmd_o.x      = brl_pkg::CoordW'(xa);
      cmd_o.y      = brl_pkg::CoordW'(ya);
      cmd_o.stop_x = brl_pkg::CoordW'(xb);
    end
    cmd_o.decision     = (dy_s <<< 1) - dx_s;
    cmd_o.inc_straight = brl_pkg::IncSW'({dy, 1'b0});
    cmd_o.inc_diagonal = brl_pkg::IncDW'(diff_s <<< 1);
  end

  assign full_o = q_full_i;
  assign q_wr_o = push_i && !q_full_i;

endmodule

@@ rtl/brl_cmd_queue.sv @@
// Short queue of prepared line commands between the front and the walker.
`include "bresenham_line_rasterizer_assert.svh"

module brl_cmd_queue #(
  parameter int unsigned DEPTH = brl_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  brl_pkg::cmd_t      cmd_i,
  output logic               full_o,
  input  logic               rd_i,
  output brl_pkg::cmd_head_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  brl_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o       = (count_q == FullCnt);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  `BRL_ASSERT(a_count_bound, count_q <= FullCnt, "Command queue count beyond its depth.")
  `BRL_ASSERT(a_no_overflow, !(wr_i && full_o), "Command written into a full queue.")
  `BRL_ASSERT(a_no_underflow, !(rd_i && !head_o.valid), "Command read from an empty queue.")

endmodule

@@ rtl/brl_walker.sv @@
// Back end: steps along one line per command and emits one pixel per beat.
`include "bresenham_line_rasterizer_assert.svh"

module brl_walker #(
  parameter int unsigned COORD_BITS = brl_pkg::CoordBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  brl_pkg::cmd_head_t head_i,
  output logic               rd_o,
  output logic               empty_o,
  input  logic               pop_i,
  output brl_pkg::pix_t      pix_o
);

  localparam logic [brl_pkg::CoordW-1:0] YMax =
    brl_pkg::CoordW'((1 << COORD_BITS) - 1);

  logic                            busy_q, busy_d;
  logic                            out_valid_q, out_valid_d;
  brl_pkg::pix_t                   out_q;
  logic [brl_pkg::CoordW-1:0]      cur_x_q, cur_y_q, stop_x_q;
  logic signed [brl_pkg::DecW-1:0] dec_q;
  logic [brl_pkg::IncSW-1:0]       inc_s_q;
  logic signed [brl_pkg::IncDW-1:0] inc_d_q;
  logic                            step, last, load;

  assign step = busy_q && (!out_valid_q || pop_i);
  assign last = (cur_x_q >= stop_x_q);
  assign load = head_i.valid && (!busy_q || (step && last));
  assign rd_o = load;

  always_comb begin
    busy_d = busy_q;
    if (load) begin
      busy_d = 1'b1;
    end else if (step && last) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.pixel_x    <= cur_x_q;
      out_q.pixel_y    <= cur_y_q;
      out_q.last_pixel <= last;
    end
    if (load) begin
      cur_x_q  <= head_i.cmd.x;
      cur_y_q  <= head_i.cmd.y;
      stop_x_q <= head_i.cmd.stop_x;
      dec_q    <= head_i.cmd.decision;
      inc_s_q  <= head_i.cmd.inc_straight;
      inc_d_q  <= head_i.cmd.inc_diagonal;
    end else if (step && !last) begin
      cur_x_q <= cur_x_q + 1'b1;
      if (dec_q[brl_pkg::DecW-1]) begin
        dec_q <= dec_q + signed'(brl_pkg::DecW'(inc_s_q));
      end else begin
        if (cur_y_q < YMax) begin
          cur_y_q <= cur_y_q + 1'b1;
        end
        dec_q <= dec_q + brl_pkg::DecW'(inc_d_q);
      end
    end
  end

  assign empty_o = !out_valid_q;
  assign pix_o   = out_q;

  `BRL_ASSERT(a_x_in_range, !busy_q || (cur_x_q <= stop_x_q),
              "Walker has passed the end of its line.")
  `BRL_ASSERT_NEXT(a_last_ends_line, step && last && !load, !busy_q,
                   "Walker still busy after the final pixel.")
  `BRL_ASSERT_NEXT(a_x_advances, step && !last && !load, cur_x_q == $past(cur_x_q) + 1'b1,
                   "Walker x did not advance by one column.")

endmodule

@@ rtl/bresenham_line_rasterizer.sv @@
// Top level of the line rasterizer: front end, command queue and walker.
//
// The block takes line requests on a queue-style input: a request beat is
// taken at a rising edge where push is high and full is low. Each request
// carries two endpoints and produces dx + 1 pixel beats, from the endpoint
// with the smaller x to the larger x, with the final pixel flagged.
// Pixels leave on a queue-style output: the oldest pixel is shown while
// empty is low and is taken at an edge where pop is high.
// A request passes into a short command queue; the walker then loads it
// into its position registers and registers each pixel into the pixel
// register. The walker produces one pixel per cycle while the receiver
// takes them, and a line of up to 64 pixels is followed by the next queued
// line without a gap. The walker's single stepping loop sets this rate.
// When the receiver stalls, the pixel register holds its beat and the
// walker waits; requests still enter until the command queue is full.
// Reset clears the queue and the walker; no pixel is pending after it.
module bresenham_line_rasterizer #(
  parameter int unsigned COORD_BITS  = brl_pkg::CoordBits,
  parameter int unsigned QUEUE_DEPTH = brl_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  brl_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output brl_pkg::pix_t pix_o
);

  logic               q_full, q_wr, q_rd;
  brl_pkg::cmd_t      cmd;
  brl_pkg::cmd_head_t head;

  brl_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .push_i   (push),
    .req_i    (req_i),
    .q_full_i (q_full),
    .full_o   (full),
    .q_wr_o   (q_wr),
    .cmd_o    (cmd)
  );

  brl_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .cmd_i  (cmd),
    .full_o (q_full),
    .rd_i   (q_rd),
    .head_o (head)
  );

  brl_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .rd_o    (q_rd),
    .empty_o (empty),
    .pop_i   (pop),
    .pix_o   (pix_o)
  );

endmodule
